### hw/rtl/sas_pkg.sv
// Package for the shape area sorter: payload word types and fixed constants.
// No dependencies.
package sas_pkg;

  localparam int AREA_W = 26;
  localparam int DIM_W  = 16;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
  localparam logic [25:0] PI_Q = 26'd52707178;

  typedef enum logic [1:0] {
    KIND_CIRCLE = 2'd0,
    KIND_RECT   = 2'd1,
    KIND_TRI    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DIM_W-1:0] dim_a;
    logic [DIM_W-1:0] dim_b;
    logic [DIM_W-1:0] dim_c;
    logic             is_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        out_kind;
    logic [AREA_W-1:0] out_area;
    logic              bad_triangle;
    logic              last_out;
  } out_word_t;

  // stored entry: bad flag, kind, area
  typedef struct packed {
    logic              bad;
    logic [1:0]        kind;
    logic [AREA_W-1:0] area;
  } entry_t;

endpackage

### hw/rtl/sas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sas_area.sv
// Area unit: circle, rectangle and Heron triangle area over several cycles.
// One multiplier step per cycle, bit-pair square root. Depends on sas_pkg.
module sas_area import sas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  in_word_t   in_word,
  output logic       done,
  output entry_t     result
);

  typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_M3, S_M4, S_SQRT} st_t;

  st_t         st_r;
  logic [1:0]  kind_r;
  logic [17:0] s_r, x_r, y_r, z_r;
  logic [35:0] u_r, v_r;
  logic [63:0] acc_r;      // product accumulator / sqrt operand
  logic [63:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;
  logic        bad_r;
  logic [AREA_W-1:0] area_r;

  logic [17:0] a18, b18, c18;
  logic signed [18:0] xs, ys, zs;
  logic [33:0] trial;
  logic [63:0] rem_sh;

  assign a18 = {2'b0, in_word.dim_a};
  assign b18 = {2'b0, in_word.dim_b};
  assign c18 = {2'b0, in_word.dim_c};
  assign xs = $signed({1'b0, b18 + c18}) - $signed({1'b0, a18});
  assign ys = $signed({1'b0, a18 + c18}) - $signed({1'b0, b18});
  assign zs = $signed({1'b0, a18 + b18}) - $signed({1'b0, c18});

  assign rem_sh = {rem_r[61:0], acc_r[63:62]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (start) begin
            kind_r <= in_word.kind;
            bad_r  <= 1'b0;
            area_r <= '0;
            s_r    <= a18 + b18 + c18;
            x_r    <= xs[17:0];
            y_r    <= ys[17:0];
            z_r    <= zs[17:0];
            case (in_word.kind)
              KIND_CIRCLE: begin
                u_r  <= {20'd0, in_word.dim_a} * {20'd0, in_word.dim_a};
                st_r <= S_M1;
              end
              KIND_RECT: begin
                u_r  <= {20'd0, in_word.dim_a} * {20'd0, in_word.dim_b};
                st_r <= S_M1;
              end
              KIND_TRI: begin
                if (xs < 0 || ys < 0 || zs < 0) begin
                  bad_r <= 1'b1;
                  done  <= 1'b1;
                end else begin
                  st_r <= S_M1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_M1: begin
          case (kind_r)
            KIND_CIRCLE: begin
              acc_r <= {28'd0, u_r} * {38'd0, PI_Q};
              st_r  <= S_M4;
            end
            KIND_RECT: begin
              acc_r <= {28'd0, u_r} + 64'd128;
              st_r  <= S_M4;
            end
            default: begin
              u_r  <= {18'd0, s_r} * {18'd0, x_r};
              v_r  <= {18'd0, y_r} * {18'd0, z_r};
              st_r <= S_M2;
            end
          endcase
        end
        S_M2: begin
          // high part: u * (v >> 20)
          acc_r <= {28'd0, u_r} * {48'd0, v_r[35:20]};
          st_r  <= S_M3;
        end
        S_M3: begin
          acc_r <= acc_r + ((({28'd0, u_r} * {44'd0, v_r[19:0]})) >> 20);
          rem_r <= '0;
          root_r <= '0;
          cnt_r <= 6'd0;
          st_r  <= S_SQRT;
        end
        S_M4: begin
          if (kind_r == KIND_CIRCLE) begin
            area_r <= ((acc_r + 64'h8000_0000) >> 32) > 64'(AREA_MAX)
                      ? AREA_MAX : AREA_W'((acc_r + 64'h8000_0000) >> 32);
          end else if (kind_r == KIND_TRI) begin
            area_r <= root_r > 32'(AREA_MAX) ? AREA_MAX : AREA_W'(root_r);
          end else begin
            area_r <= (acc_r >> 8) > 64'(AREA_MAX) ? AREA_MAX : AREA_W'(acc_r >> 8);
          end
          done <= 1'b1;
          st_r <= S_IDLE;
        end
        S_SQRT: begin
          // one result bit per cycle
          acc_r <= {acc_r[61:0], 2'b00};
          if (rem_sh >= {30'd0, trial}) begin
            rem_r  <= rem_sh - {30'd0, trial};
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            st_r <= S_M4;
            kind_r <= KIND_TRI;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign result = '{bad: bad_r, kind: kind_r, area: area_r};

endmodule

### hw/rtl/shape_area_sorter_top.sv
// Shape area sorter top level. Depends on sas_pkg, sas_area, sas_ram.
// Per shape: a broken triangle or undefined kind finishes in S_IDLE, a circle or
// rectangle runs S_M1 and S_M4, a triangle runs S_M1 to S_M3, a bit-pair square root and S_M4.
// A last-marked shape then emits n words, each found by a scan of the entry
// memory with one read a cycle; each word is held until out_ready.
// Reset (synchronous, rst_n low) empties the store; memory contents are kept.
module shape_area_sorter_top import sas_pkg::*; #(
  parameter int MAX_SHAPES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int IW = $clog2(MAX_SHAPES);
  localparam int CW = $clog2(MAX_SHAPES + 1);

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_SCAN, S_EMIT} st_t;

  st_t         st_r;
  in_word_t    item_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] done_cnt_r;   // words emitted
  logic [CW-1:0] ridx_r;       // read address issued
  logic          rv_r;         // read data valid in rdata
  logic [IW-1:0] cidx_r;       // index of data in rdata
  // previous emitted key (area, index); candidate best
  logic [AREA_W-1:0] pa_r;
  logic [IW-1:0]     pi_r;
  logic              have_prev_r;
  entry_t            best_r;
  logic [IW-1:0]     bi_r;
  logic              have_best_r;

  logic   start, adone, we;
  entry_t ares, rdata;
  logic   gt_prev, lt_best;

  sas_area u_area (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_data),
    .done(adone), .result(ares)
  );

  assign we = adone && (cnt_r < CW'(MAX_SHAPES));

  sas_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SHAPES)) u_ram (
    .clk(clk), .we(we), .waddr(cnt_r[IW-1:0]), .wdata(ares),
    .raddr(ridx_r[IW-1:0]), .rdata(rdata)
  );

  assign in_ready = (st_r == S_IDLE);
  assign start    = in_valid && in_ready;

  // key order: area then index
  assign gt_prev = !have_prev_r || rdata.area > pa_r ||
                   (rdata.area == pa_r && cidx_r > pi_r);
  assign lt_best = !have_best_r || rdata.area < best_r.area;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
      rv_r      <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (start) begin
            item_r <= in_data;
            st_r   <= S_CALC;
          end
        end
        S_CALC: begin
          if (adone) begin
            if (we) cnt_r <= cnt_r + CW'(1);
            if (item_r.is_last) begin
              done_cnt_r  <= '0;
              have_prev_r <= 1'b0;
              have_best_r <= 1'b0;
              ridx_r      <= '0;
              rv_r        <= 1'b0;
              st_r        <= (we || cnt_r != '0) ? S_SCAN : S_IDLE;
            end else begin
              st_r <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          if (ridx_r < cnt_r) begin
            cidx_r <= ridx_r[IW-1:0];
            ridx_r <= ridx_r + CW'(1);
            rv_r   <= 1'b1;
          end else begin
            rv_r <= 1'b0;
          end
          if (rv_r && gt_prev && lt_best) begin
            best_r      <= rdata;
            bi_r        <= cidx_r;
            have_best_r <= 1'b1;
          end
          if (!rv_r && ridx_r == cnt_r) begin
            out_data  <= '{out_kind: best_r.kind, out_area: best_r.area,
                           bad_triangle: best_r.bad,
                           last_out: (done_cnt_r + CW'(1) == cnt_r)};
            out_valid <= 1'b1;
            st_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid   <= 1'b0;
            pa_r        <= best_r.area;
            pi_r        <= bi_r;
            have_prev_r <= 1'b1;
            have_best_r <= 1'b0;
            ridx_r      <= '0;
            done_cnt_r  <= done_cnt_r + CW'(1);
            if (done_cnt_r + CW'(1) == cnt_r) begin
              cnt_r <= '0;
              st_r  <= S_IDLE;
            end else begin
              st_r <= S_SCAN;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
